// ----- src/nitt_pkg.sv -----
// Shared types and constants for the NAT translation table.
package nitt_pkg;

   // Result codes
   typedef enum logic [1:0] {
      ST_EXISTING  = 2'd0,
      ST_NEW       = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Control register indexes
   typedef enum logic [1:0] {
      CSR_OUTSIDE_ADDRESS = 2'd0,
      CSR_PORT_FIRST      = 2'd1,
      CSR_PORT_LAST       = 2'd2
   } csr_index_type;

   localparam logic [15:0] PORT_FIRST_RESET = 16'd1024;
   localparam logic [15:0] PORT_LAST_RESET  = 16'd65535;

   // One stored mapping
   typedef struct packed {
      logic        kind;
      logic [31:0] host;
      logic [15:0] inner_id;
      logic [15:0] outer_id;
   } slot_type;

endpackage

// ----- src/nitt_if.sv -----
// Valid/ready channels for request and response words.
interface nitt_req_if;
   logic        valid;
   logic        ready;
   logic        inbound;
   logic        entry_kind;
   logic [31:0] host_address;
   logic [15:0] ident;

   modport source (output valid, inbound, entry_kind, host_address, ident, input ready);
   modport sink (input valid, inbound, entry_kind, host_address, ident, output ready);
endinterface

interface nitt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] new_address;
   logic [15:0] new_ident;

   modport source (output valid, status, new_address, new_ident, input ready);
   modport sink (input valid, status, new_address, new_ident, output ready);
endinterface

// ----- src/nitt_entry_ram.sv -----
// Single-port-write, single-port-read table memory with registered read data.
module nitt_entry_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  nitt_pkg::slot_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output nitt_pkg::slot_type rd_data
);
   import nitt_pkg::*;

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/nat_icmp_translation_table.sv -----
// NAT address/identifier translation table: outbound lookup with insert, inbound reverse lookup.
//
// Each request word carries a direction, a mapping kind, a host address and an id. Entries
// live in one memory and fill slots in order; a slot below the fill count is valid, so no
// clearing pass is needed after reset. A lookup walks the filled slots from the newest down,
// one memory read per cycle, and stops at the first hit; an empty table skips the walk. The
// fill count reaches at most TABLE_ENTRIES. An outbound miss on a table that is not full
// stores a new slot with the next external id from a counter that wraps from port_last back
// to port_first. One request is in flight at a time; the response register lets the next
// request be taken while a response still waits.
module nat_icmp_translation_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   nitt_req_if.sink          req_chan,
   nitt_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import nitt_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [15:0] next_port_ff, next_port_in;
   logic [31:0] outside_address_ff, outside_address_in;
   logic [15:0] port_first_ff, port_first_in;
   logic [15:0] port_last_ff, port_last_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic        hit_ff, hit_in;
   slot_type    hit_slot_ff, hit_slot_in;

   // captured request
   logic        inbound_ff, inbound_in;
   logic        kind_ff, kind_in;
   logic [31:0] host_ff, host_in;
   logic [15:0] ident_ff, ident_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_address_ff, rsp_address_in;
   logic [15:0] rsp_ident_ff, rsp_ident_in;

   logic          ram_wr_en;
   slot_type      ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   slot_type      ram_rd_data;
   logic [CW-1:0] fill_m1;
   logic          match;

   nitt_entry_ram #(
      .DEPTH (TABLE_ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign fill_m1 = fill_ff - CW'(1);

   always_comb begin
      if (inbound_ff) begin
         match = (ram_rd_data.kind == kind_ff) && (ram_rd_data.outer_id == ident_ff);
      end else begin
         match = (ram_rd_data.kind == kind_ff) && (ram_rd_data.host == host_ff) &&
                 (ram_rd_data.inner_id == ident_ff);
      end
   end

   always_comb begin
      state_in           = state_ff;
      fill_in            = fill_ff;
      next_port_in       = next_port_ff;
      outside_address_in = outside_address_ff;
      port_first_in      = port_first_ff;
      port_last_in       = port_last_ff;
      ptr_in             = ptr_ff;
      hit_in             = hit_ff;
      hit_slot_in        = hit_slot_ff;
      inbound_in         = inbound_ff;
      kind_in            = kind_ff;
      host_in            = host_ff;
      ident_in           = ident_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in      = rsp_status_ff;
      rsp_address_in     = rsp_address_ff;
      rsp_ident_in       = rsp_ident_ff;
      ram_wr_en          = 1'b0;
      ram_wr_data        = '{kind: kind_ff, host: host_ff, inner_id: ident_ff,
                             outer_id: next_port_ff};
      ram_rd_addr        = ptr_ff - AW'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               inbound_in = req_chan.inbound;
               kind_in    = req_chan.entry_kind;
               host_in    = req_chan.host_address;
               ident_in   = req_chan.ident;
               hit_in     = 1'b0;
               if (fill_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  ptr_in      = fill_m1[AW-1:0];
                  ram_rd_addr = fill_m1[AW-1:0];
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // read data here belongs to slot ptr_ff; newest slot wins
            if (match) begin
               hit_in      = 1'b1;
               hit_slot_in = ram_rd_data;
               state_in    = S_FINISH;
            end else if (ptr_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               ptr_in      = ptr_ff - AW'(1);
               ram_rd_addr = ptr_ff - AW'(1);
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (inbound_ff) begin
                  if (hit_ff) begin
                     rsp_status_in  = ST_EXISTING;
                     rsp_address_in = hit_slot_ff.host;
                     rsp_ident_in   = hit_slot_ff.inner_id;
                  end else begin
                     rsp_status_in  = ST_NOT_FOUND;
                     rsp_address_in = '0;
                     rsp_ident_in   = '0;
                  end
               end else if (hit_ff) begin
                  rsp_status_in  = ST_EXISTING;
                  rsp_address_in = outside_address_ff;
                  rsp_ident_in   = hit_slot_ff.outer_id;
               end else if (fill_ff == CW'(TABLE_ENTRIES)) begin
                  rsp_status_in  = ST_FULL;
                  rsp_address_in = '0;
                  rsp_ident_in   = '0;
               end else begin
                  rsp_status_in  = ST_NEW;
                  rsp_address_in = outside_address_ff;
                  rsp_ident_in   = next_port_ff;
                  ram_wr_en      = 1'b1;
                  fill_in        = fill_ff + CW'(1);
                  if (next_port_ff >= port_last_ff) begin
                     next_port_in = port_first_ff;
                  end else begin
                     next_port_in = next_port_ff + 16'd1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OUTSIDE_ADDRESS: outside_address_in = csr_wdata;
            CSR_PORT_FIRST: begin
               port_first_in = csr_wdata[15:0];
               next_port_in  = csr_wdata[15:0];
            end
            CSR_PORT_LAST: port_last_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      state_ff           <= state_in;
      fill_ff            <= fill_in;
      next_port_ff       <= next_port_in;
      outside_address_ff <= outside_address_in;
      port_first_ff      <= port_first_in;
      port_last_ff       <= port_last_in;
      ptr_ff             <= ptr_in;
      hit_ff             <= hit_in;
      hit_slot_ff        <= hit_slot_in;
      inbound_ff         <= inbound_in;
      kind_ff            <= kind_in;
      host_ff            <= host_in;
      ident_ff           <= ident_in;
      rsp_valid_ff       <= rsp_valid_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_address_ff     <= rsp_address_in;
      rsp_ident_ff       <= rsp_ident_in;
      if (reset) begin
         state_ff           <= S_IDLE;
         fill_ff            <= '0;
         next_port_ff       <= PORT_FIRST_RESET;
         outside_address_ff <= '0;
         port_first_ff      <= PORT_FIRST_RESET;
         port_last_ff       <= PORT_LAST_RESET;
         rsp_valid_ff       <= 1'b0;
      end
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.new_address  = rsp_address_ff;
   assign rsp_chan.new_ident    = rsp_ident_ff;

endmodule
